@@ rtl/assert_macros.svh @@
// assertion helpers used by the parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain check sampled on the rising clock edge, muted in reset
`define WRP_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication checked on the next clock edge
`define WRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wrp_pkg.sv @@
// ----------------------------------------------------------------------------
// wrp_pkg
// Types and constants for the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
package wrp_pkg;

  // four-character chunk tags, first character in the low byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_CUE  = 32'h2065_7563;
  localparam logic [31:0] TAG_LIST = 32'h5453_494c;
  localparam logic [31:0] TAG_MARK = 32'h6b72_616d;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [7:0] SIGN_FLIP = 8'd128;

  // parse phases; numeric order is used for range checks
  typedef enum logic [3:0] {
    PH_OUTER_HDR  = 4'd0,
    PH_OUTER_SKIP = 4'd1,
    PH_WAVE_ID    = 4'd2,
    PH_SUB_HDR    = 4'd3,
    PH_FMT        = 4'd4,
    PH_CUE        = 4'd5,
    PH_LIST       = 4'd6,
    PH_OTHER      = 4'd7,
    PH_PAYLOAD    = 4'd8,
    PH_DEAD       = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    K_SAMPLE = 2'd0,
    K_REPORT = 2'd1,
    K_ERROR  = 2'd2,
    K_DONE   = 2'd3
  } kind_t;

  // status codes
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_NO_WAVE  = 4'd1;
  localparam logic [3:0] ST_NO_FMT   = 4'd2;
  localparam logic [3:0] ST_NOT_PCM  = 4'd3;
  localparam logic [3:0] ST_CHANNELS = 4'd4;
  localparam logic [3:0] ST_WIDTH    = 4'd5;
  localparam logic [3:0] ST_NO_DATA  = 4'd6;
  localparam logic [3:0] ST_LOOP     = 4'd7;
  localparam logic [3:0] ST_EMPTY    = 4'd8;
  localparam logic [3:0] ST_NEG_LEN  = 4'd9;

  // seen flag bits
  localparam int SEEN_FMT  = 0;
  localparam int SEEN_CUE  = 1;
  localparam int SEEN_LIST = 2;

  typedef struct packed {
    kind_t        kind;
    logic [7:0]   sample_byte;
    logic [1:0]   channel_count;
    logic [31:0]  sample_rate;
    logic [1:0]   sample_width;
    logic [31:0]  loop_start;
    logic [30:0]  frame_count;
    logic [3:0]   status;
  } result_t;

  // chunk length rounded up to even
  function automatic logic [31:0] padded(input logic [31:0] s);
    logic [31:0] t;
    t = s + 32'd1;
    return {t[31:1], 1'b0};
  endfunction

  function automatic result_t mk_simple(input kind_t k, input logic [7:0] b,
                                        input logic [3:0] st);
    result_t r;
    r             = '0;
    r.kind        = k;
    r.sample_byte = b;
    r.status      = st;
    return r;
  endfunction

endpackage

@@ rtl/wav_riff_header_parser_core.sv @@
// Results are written into a registered result queue and are read out from its head.
// One byte per cycle while in_stall is low; the parse step and queue write happen in the same cycle.
// A byte may give two results; input stalls when the 4-entry queue has fewer than 2 free.
// Reset (rst, synchronous, active high) returns the parser to the outer chunk header
// and empties the result queue; the final byte of a file also restarts the parser.
// ----------------------------------------------------------------------------
// wav_riff_header_parser_core
// Byte-serial RIFF/WAVE PCM parser: walks chunks, picks up fmt/cue/mark
// fields, reports the format and streams the payload bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wav_riff_header_parser_core #(
  parameter int QDEPTH_LOG2 = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            sample_byte,
  output logic [1:0]            channel_count,
  output logic [31:0]           sample_rate,
  output logic [1:0]            sample_width,
  output logic signed [31:0]    loop_start,
  output logic [30:0]           frame_count,
  output logic [3:0]            status
);
  import wrp_pkg::*;

  localparam int QDEPTH = 1 << QDEPTH_LOG2;

  // parser state
  phase_t      phase, phase_next;
  logic [31:0] file_offset, file_offset_next;
  logic [31:0] chunk_tag, chunk_tag_next;
  logic [31:0] chunk_size, chunk_size_next;
  logic [31:0] next_off, next_off_next;
  logic [31:0] field_shift, field_shift_next;
  logic [2:0]  seen, seen_next;
  logic [1:0]  held_channels, held_channels_next;
  logic [31:0] held_rate, held_rate_next;
  logic [1:0]  held_width, held_width_next;
  logic [31:0] held_loop_start, held_loop_start_next;
  logic [31:0] held_loop_frames, held_loop_frames_next;
  logic [31:0] bytes_to_emit, bytes_to_emit_next;
  logic [3:0]  fmt_verdict, fmt_verdict_next;

  // results of this byte
  result_t     res0, res1;
  logic [1:0]  nres;

  // helpers
  logic [31:0] hdr_pos, body_pos, half, bytes_left;
  logic [31:0] s_frames;
  logic signed [32:0] s_x, loop_x, total_x;
  logic [31:0] frames;
  logic [3:0]  verdict, end_code;
  logic        accept, pop;

  assign accept = in_valid && !in_stall;

  // result queue
  result_t                 queue [QDEPTH];
  logic [QDEPTH_LOG2-1:0]  wr_ptr, rd_ptr;
  logic [QDEPTH_LOG2:0]    count;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (count > (QDEPTH_LOG2+1)'(QDEPTH - 2));

  // one parse step per byte
  always_comb begin
    phase_next            = phase;
    file_offset_next      = file_offset + 32'd1;
    chunk_tag_next        = chunk_tag;
    chunk_size_next       = chunk_size;
    next_off_next         = next_off;
    field_shift_next      = {in_byte, field_shift[31:8]};
    seen_next             = seen;
    held_channels_next    = held_channels;
    held_rate_next        = held_rate;
    held_width_next       = held_width;
    held_loop_start_next  = held_loop_start;
    held_loop_frames_next = held_loop_frames;
    bytes_to_emit_next    = bytes_to_emit;
    fmt_verdict_next      = fmt_verdict;
    res0 = '0;
    res1 = '0;
    nres = 2'd0;

    hdr_pos  = file_offset - next_off;
    body_pos = file_offset - (next_off - padded(chunk_size));
    half     = {16'd0, field_shift_next[31:16]};
    bytes_left = bytes_to_emit - 32'd1;

    // data chunk arithmetic, size taken from the incoming length
    verdict  = seen[SEEN_FMT] ? fmt_verdict : ST_NO_FMT;
    s_frames = (held_width == 2'd2) ? {1'b0, field_shift_next[31:1]} : field_shift_next;
    s_x      = {1'b0, s_frames};
    loop_x   = {held_loop_frames[31], held_loop_frames};
    total_x  = (held_loop_frames != '0) ? loop_x : s_x;
    frames   = (held_channels == 2'd2) ? total_x[32:1] : total_x[31:0];

    unique case (phase)
      PH_OUTER_HDR, PH_SUB_HDR: begin
        if (hdr_pos == 32'd3) begin
          chunk_tag_next = field_shift_next;
        end else if (hdr_pos == 32'd7) begin
          chunk_size_next = field_shift_next;
          next_off_next   = file_offset + 32'd1 + padded(field_shift_next);
          if (field_shift_next[31]) begin
            res0 = mk_simple(K_ERROR, 8'd0, ST_NEG_LEN); nres = 2'd1;
            phase_next = PH_DEAD;
          end else if (phase == PH_OUTER_HDR) begin
            if (chunk_tag == TAG_RIFF) begin
              next_off_next = file_offset + 32'd5;
              phase_next    = PH_WAVE_ID;
            end else begin
              phase_next = PH_OUTER_SKIP;
            end
          end else if (chunk_tag == TAG_DATA) begin
            // checks and format report
            if (verdict != ST_OK) begin
              res0 = mk_simple(K_ERROR, 8'd0, verdict); nres = 2'd1;
              phase_next = PH_DEAD;
            end else if (held_loop_frames != '0 && s_x < loop_x) begin
              res0 = mk_simple(K_ERROR, 8'd0, ST_LOOP); nres = 2'd1;
              phase_next = PH_DEAD;
            end else if (total_x <= 33'sd0) begin
              res0 = mk_simple(K_ERROR, 8'd0, ST_EMPTY); nres = 2'd1;
              phase_next = PH_DEAD;
            end else begin
              bytes_to_emit_next = frames << ((held_width == 2'd2 ? 1 : 0)
                                              + (held_channels == 2'd2 ? 1 : 0));
              res0               = '0;
              res0.kind          = K_REPORT;
              res0.channel_count = held_channels;
              res0.sample_rate   = held_rate;
              res0.sample_width  = held_width;
              res0.loop_start    = held_loop_start;
              res0.frame_count   = frames[30:0];
              nres = 2'd1;
              if (bytes_to_emit_next == '0) begin
                res1 = mk_simple(K_DONE, 8'd0, ST_OK); nres = 2'd2;
                phase_next = PH_DEAD;
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end
          end else if (chunk_tag == TAG_FMT && !seen[SEEN_FMT]) begin
            seen_next[SEEN_FMT] = 1'b1;
            fmt_verdict_next    = ST_NOT_PCM;
            held_channels_next  = '0;
            held_width_next     = '0;
            held_rate_next      = '0;
            phase_next          = PH_FMT;
          end else if (chunk_tag == TAG_CUE && !seen[SEEN_CUE]) begin
            seen_next[SEEN_CUE]  = 1'b1;
            held_loop_start_next = '0;
            phase_next           = PH_CUE;
          end else if (chunk_tag == TAG_LIST && seen[SEEN_CUE] && !seen[SEEN_LIST]) begin
            seen_next[SEEN_LIST] = 1'b1;
            phase_next           = PH_LIST;
          end else begin
            phase_next = PH_OTHER;
          end
        end
      end
      PH_WAVE_ID: begin
        if (file_offset + 32'd1 == next_off) begin
          if (field_shift_next == TAG_WAVE) begin
            phase_next = PH_SUB_HDR;
          end else begin
            res0 = mk_simple(K_ERROR, 8'd0, ST_NO_WAVE); nres = 2'd1;
            phase_next = PH_DEAD;
          end
        end
      end
      PH_FMT: begin
        if (body_pos == 32'd1) begin
          if (fmt_verdict == ST_NOT_PCM && half == 32'd1) fmt_verdict_next = ST_CHANNELS;
        end else if (body_pos == 32'd3) begin
          if (fmt_verdict == ST_CHANNELS && (half == 32'd1 || half == 32'd2)) begin
            held_channels_next = half[1:0];
            fmt_verdict_next   = ST_WIDTH;
          end
        end else if (body_pos == 32'd7) begin
          held_rate_next = field_shift_next;
        end else if (body_pos == 32'd15) begin
          if (fmt_verdict == ST_WIDTH && half >= 32'd8 && half <= 32'd23) begin
            held_width_next  = half[4:3];
            fmt_verdict_next = ST_OK;
          end
        end
      end
      PH_CUE: begin
        if (body_pos == 32'd27) held_loop_start_next = field_shift_next;
      end
      PH_LIST: begin
        if (body_pos == 32'd19) begin
          chunk_tag_next = held_loop_start + field_shift_next;
        end else if (body_pos == 32'd23 && field_shift_next == TAG_MARK) begin
          held_loop_frames_next = chunk_tag;
        end
      end
      PH_PAYLOAD: begin
        res0 = mk_simple(K_SAMPLE,
                         (held_width == 2'd1) ? (in_byte ^ SIGN_FLIP) : in_byte, ST_OK);
        nres = 2'd1;
        bytes_to_emit_next = bytes_left;
        if (bytes_left == '0) begin
          res1 = mk_simple(K_DONE, 8'd0, ST_OK); nres = 2'd2;
          phase_next = PH_DEAD;
        end
      end
      default: begin
      end
    endcase

    // chunk end returns to the header walk
    if (file_offset + 32'd1 == next_off_next) begin
      if (phase_next == PH_OUTER_SKIP) begin
        phase_next = PH_OUTER_HDR;
      end else if (phase_next >= PH_FMT && phase_next <= PH_OTHER) begin
        phase_next = PH_SUB_HDR;
      end
    end

    // end of file verdict
    end_code = seen_next[SEEN_FMT] ? fmt_verdict_next : ST_NO_FMT;
    if (phase_next <= PH_WAVE_ID) begin
      end_code = ST_NO_WAVE;
    end else if (end_code == ST_OK) begin
      end_code = ST_NO_DATA;
    end
    if (in_last) begin
      if (phase_next == PH_PAYLOAD) begin
        if (nres == 2'd0) begin
          res0 = mk_simple(K_DONE, 8'd0, ST_OK);
        end else begin
          res1 = mk_simple(K_DONE, 8'd0, ST_OK);
        end
        nres = nres + 2'd1;
      end else if (phase_next != PH_DEAD) begin
        res0 = mk_simple(K_ERROR, 8'd0, end_code);
        nres = 2'd1;
      end
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst || (accept && in_last)) begin
      phase            <= PH_OUTER_HDR;
      file_offset      <= '0;
      chunk_tag        <= '0;
      chunk_size       <= '0;
      next_off         <= '0;
      field_shift      <= '0;
      seen             <= '0;
      held_channels    <= '0;
      held_rate        <= '0;
      held_width       <= '0;
      held_loop_start  <= '1;
      held_loop_frames <= '0;
      bytes_to_emit    <= '0;
      fmt_verdict      <= ST_OK;
    end else if (accept) begin
      phase            <= phase_next;
      file_offset      <= file_offset_next;
      chunk_tag        <= chunk_tag_next;
      chunk_size       <= chunk_size_next;
      next_off         <= next_off_next;
      field_shift      <= field_shift_next;
      seen             <= seen_next;
      held_channels    <= held_channels_next;
      held_rate        <= held_rate_next;
      held_width       <= held_width_next;
      held_loop_start  <= held_loop_start_next;
      held_loop_frames <= held_loop_frames_next;
      bytes_to_emit    <= bytes_to_emit_next;
      fmt_verdict      <= fmt_verdict_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (accept && nres != 2'd0) begin
      queue[wr_ptr] <= res0;
      if (nres == 2'd2) queue[wr_ptr + QDEPTH_LOG2'(1)] <= res1;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + QDEPTH_LOG2'(nres);
      if (pop) rd_ptr <= rd_ptr + QDEPTH_LOG2'(1);
      count <= count + (accept ? (QDEPTH_LOG2+1)'(nres) : '0)
                     - (pop ? (QDEPTH_LOG2+1)'(1) : '0);
    end
  end

  // output transaction fields
  assign out_kind      = queue[rd_ptr].kind;
  assign sample_byte   = queue[rd_ptr].sample_byte;
  assign channel_count = queue[rd_ptr].channel_count;
  assign sample_rate   = queue[rd_ptr].sample_rate;
  assign sample_width  = queue[rd_ptr].sample_width;
  assign loop_start    = queue[rd_ptr].loop_start;
  assign frame_count   = queue[rd_ptr].frame_count;
  assign status        = queue[rd_ptr].status;

  // checks; the top count bit marks a full queue
  `WRP_ASSERT(a_queue_bound, count <= (QDEPTH_LOG2+1)'(QDEPTH), "result queue overflow")
  `WRP_ASSERT(a_ptrs, (count == '0) || count[QDEPTH_LOG2] || (wr_ptr != rd_ptr), "ptr mismatch")
  `WRP_ASSERT_NEXT(a_restart, accept && in_last, phase == PH_OUTER_HDR, "no restart at end")

endmodule
